[src/opc_pkg.sv]
package opc_pkg;

   // Guess table geometry.
   localparam int TABLE_DEPTH = 32768;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

   // Width of the raw history hash (prev_one << 7) ^ prev_two.
   localparam int HASH_W = 15;

   // Value of every table entry after reset.
   localparam logic [7:0] GUESS_INIT = 8'd32;

   // Bytes per mask group.
   localparam logic [3:0] GROUP_SIZE = 4'd8;

   // Table memory access request from the sequencer.
   typedef struct packed {
      logic                rd_en;
      logic [TABLE_AW-1:0] rd_addr;
      logic                wr_en;
      logic [TABLE_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
   } opc_ram_req_type;

   // One result byte handed to the output stage.
   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       last;
   } opc_emit_type;

endpackage

[src/opc_req_if.sv]
interface opc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       flush;

   modport source (output valid, output data_byte, output flush, input ready);
   modport sink (input valid, input data_byte, input flush, output ready);
endinterface

[src/opc_rsp_if.sv]
interface opc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink (input valid, input out_byte, input last, output ready);
endinterface

[src/opc_table_ram.sv]
module opc_table_ram (
   input  logic                     clock,
   input  opc_pkg::opc_ram_req_type ram_req,
   output logic [7:0]               rd_data
);
   import opc_pkg::*;

   logic [7:0] mem [TABLE_DEPTH];
   logic [7:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/opc_rsp_stage.sv]
module opc_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  opc_pkg::opc_emit_type emit,
   output logic                  out_free,
   opc_rsp_if.source             rsp_port
);
   import opc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // The register can take a new byte when empty or being drained now.
   assign out_free = !valid_ff || rsp_port.ready;

   always_comb begin
      valid_in = valid_ff;
      if (emit.valid) begin
         valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         byte_ff <= emit.out_byte;
         last_ff <= emit.last;
      end
   end

   assign rsp_port.valid    = valid_ff;
   assign rsp_port.out_byte = byte_ff;
   assign rsp_port.last     = last_ff;

endmodule

[src/opc_seq.sv]
module opc_seq (
   input  logic                     clock,
   input  logic                     reset,
   opc_req_if.sink                  req_port,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data,
   input  logic                     out_free,
   output opc_pkg::opc_emit_type    emit,
   output opc_pkg::opc_ram_req_type ram_req,
   input  logic [7:0]               rd_data
);
   import opc_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_EMASK = 3'd3;
   localparam logic [2:0] ST_ELIT  = 3'd4;
   localparam logic [2:0] ST_DLIT  = 3'd5;
   localparam logic [2:0] ST_DRUN  = 3'd6;
   localparam logic [2:0] ST_DWAIT = 3'd7;

   localparam logic [TABLE_AW-1:0] CLR_LAST = TABLE_AW'(TABLE_DEPTH - 1);

   logic [2:0]          state_ff, state_in;
   logic                mode_ff, mode_in;
   logic [7:0]          prev_one_ff, prev_one_in;
   logic [7:0]          prev_two_ff, prev_two_in;
   logic [7:0]          hit_mask_ff, hit_mask_in;
   logic [3:0]          group_count_ff, group_count_in;
   logic [3:0]          lit_count_ff, lit_count_in;
   logic                awaiting_ff, awaiting_in;
   logic [7:0]          byte_ff, byte_in;
   logic [2:0]          emit_idx_ff, emit_idx_in;
   logic [TABLE_AW-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]          lit_buf_ff [8];
   logic                lit_wr;

   logic [HASH_W-1:0]   hash;
   logic [TABLE_AW-1:0] idx;
   logic [3:0]          gc_next;
   logic                more_hits;

   // Table index from the two most recent bytes.
   assign hash    = {prev_one_ff, 7'b0} ^ {7'b0, prev_two_ff};
   assign idx     = TABLE_AW'(hash);
   assign gc_next = group_count_ff + 4'd1;
   // Another predicted byte follows in the current mask.
   assign more_hits = (gc_next < GROUP_SIZE) && hit_mask_ff[gc_next[2:0]];

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      prev_one_in    = prev_one_ff;
      prev_two_in    = prev_two_ff;
      hit_mask_in    = hit_mask_ff;
      group_count_in = group_count_ff;
      lit_count_in   = lit_count_ff;
      awaiting_in    = awaiting_ff;
      byte_in        = byte_ff;
      emit_idx_in    = emit_idx_ff;
      clr_addr_in    = clr_addr_ff;
      lit_wr         = 1'b0;
      ram_req        = '0;
      emit           = '0;
      req_port.ready = 1'b0;

      case (state_ff)
         // Clearing pass: one table entry per cycle after reset.
         ST_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = clr_addr_ff;
            ram_req.wr_data = GUESS_INIT;
            clr_addr_in     = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end

         // Take one transaction and dispatch on mode and flush.
         ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               byte_in = req_port.data_byte;
               if (!mode_ff) begin
                  if (req_port.flush) begin
                     if (group_count_ff != 4'd0) begin
                        state_in = ST_EMASK;
                     end
                  end else begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = idx;
                     state_in        = ST_CMP;
                  end
               end else begin
                  if (req_port.flush) begin
                     hit_mask_in    = 8'd0;
                     group_count_in = 4'd0;
                     lit_count_in   = 4'd0;
                     awaiting_in    = 1'b0;
                  end else if (awaiting_ff && (group_count_ff < GROUP_SIZE)) begin
                     state_in = ST_DLIT;
                  end else begin
                     hit_mask_in    = req_port.data_byte;
                     group_count_in = 4'd0;
                     state_in       = ST_DRUN;
                  end
               end
            end
         end

         // Compress: compare the guess, update the table on a miss.
         ST_CMP: begin
            if (rd_data == byte_ff) begin
               hit_mask_in = hit_mask_ff | (8'd1 << group_count_ff[2:0]);
            end else begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = idx;
               ram_req.wr_data = byte_ff;
               if (lit_count_ff < GROUP_SIZE) begin
                  lit_wr       = 1'b1;
                  lit_count_in = lit_count_ff + 4'd1;
               end
            end
            group_count_in = gc_next;
            prev_one_in    = prev_two_ff;
            prev_two_in    = byte_ff;
            state_in       = (gc_next == GROUP_SIZE) ? ST_EMASK : ST_IDLE;
         end

         // Compress: send the mask byte.
         ST_EMASK: begin
            if (out_free) begin
               emit.valid    = 1'b1;
               emit.out_byte = hit_mask_ff;
               emit.last     = (lit_count_ff == 4'd0);
               emit_idx_in   = 3'd0;
               if (lit_count_ff == 4'd0) begin
                  hit_mask_in    = 8'd0;
                  group_count_in = 4'd0;
                  awaiting_in    = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_ELIT;
               end
            end
         end

         // Compress: send the buffered literals in order.
         ST_ELIT: begin
            if (out_free) begin
               emit.valid    = 1'b1;
               emit.out_byte = lit_buf_ff[emit_idx_ff];
               emit.last     = (({1'b0, emit_idx_ff} + 4'd1) == lit_count_ff);
               emit_idx_in   = emit_idx_ff + 3'd1;
               if (emit.last) begin
                  hit_mask_in    = 8'd0;
                  group_count_in = 4'd0;
                  lit_count_in   = 4'd0;
                  awaiting_in    = 1'b0;
                  state_in       = ST_IDLE;
               end
            end
         end

         // Decompress: a literal updates the table and is passed on.
         ST_DLIT: begin
            if (out_free) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = idx;
               ram_req.wr_data = byte_ff;
               emit.valid      = 1'b1;
               emit.out_byte   = byte_ff;
               emit.last       = !more_hits;
               prev_one_in     = prev_two_ff;
               prev_two_in     = byte_ff;
               group_count_in  = gc_next;
               state_in        = ST_DRUN;
            end
         end

         // Decompress: read the guess for a set mask bit, or stop.
         ST_DRUN: begin
            if ((group_count_ff < GROUP_SIZE) && hit_mask_ff[group_count_ff[2:0]]) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = idx;
               state_in        = ST_DWAIT;
            end else begin
               if (group_count_ff >= GROUP_SIZE) begin
                  group_count_in = 4'd0;
                  awaiting_in    = 1'b0;
               end else begin
                  awaiting_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         // Decompress: send the predicted byte.
         ST_DWAIT: begin
            if (out_free) begin
               emit.valid     = 1'b1;
               emit.out_byte  = rd_data;
               emit.last      = !more_hits;
               prev_one_in    = prev_two_ff;
               prev_two_in    = rd_data;
               group_count_in = gc_next;
               state_in       = ST_DRUN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A mode change drops the group in progress.
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         if (csr_wr_data != mode_ff) begin
            hit_mask_in    = 8'd0;
            group_count_in = 4'd0;
            lit_count_in   = 4'd0;
            awaiting_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         mode_ff        <= 1'b0;
         prev_one_ff    <= 8'd0;
         prev_two_ff    <= 8'd0;
         hit_mask_ff    <= 8'd0;
         group_count_ff <= 4'd0;
         lit_count_ff   <= 4'd0;
         awaiting_ff    <= 1'b0;
         emit_idx_ff    <= 3'd0;
         clr_addr_ff    <= '0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         prev_one_ff    <= prev_one_in;
         prev_two_ff    <= prev_two_in;
         hit_mask_ff    <= hit_mask_in;
         group_count_ff <= group_count_in;
         lit_count_ff   <= lit_count_in;
         awaiting_ff    <= awaiting_in;
         emit_idx_ff    <= emit_idx_in;
         clr_addr_ff    <= clr_addr_in;
      end
   end

   // Latched input byte and literal buffer hold payload only.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (lit_wr) begin
         lit_buf_ff[lit_count_ff[2:0]] <= byte_ff;
      end
   end

endmodule

[src/order2_predictor_codec_unit.sv]
// Channel   Direction  Signals                               Meaning
// req_port  in         valid ready data_byte flush           raw, mask or literal byte
// rsp_port  out        valid ready out_byte last             mask, literal or decoded byte
// csr       in         csr_wr_en csr_wr_data                 mode: 0 compress, 1 decompress
//
// Compress reads the table for a byte, then compares and writes back; a full or flushed
// group then sends 1 result per cycle while the output register is free: the mask and up
// to 8 literals. Decompress reads the guess for each predicted byte, then sends it.
// After reset a clearing pass writes all 32768 table entries, one per cycle; req_port
// stays not ready until the pass ends. Reset is synchronous and active high.
// A result waits whenever the output register is full and rsp_port is not ready.
module order2_predictor_codec_unit (
   input  logic      clock,
   input  logic      reset,
   opc_req_if.sink   req_port,
   opc_rsp_if.source rsp_port,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);
   import opc_pkg::*;

   opc_ram_req_type ram_req;
   opc_emit_type    emit;
   logic [7:0]      rd_data;
   logic            out_free;

   opc_table_ram u_table_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   opc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .out_free    (out_free),
      .emit        (emit),
      .ram_req     (ram_req),
      .rd_data     (rd_data)
   );

   opc_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .out_free (out_free),
      .rsp_port (rsp_port)
   );

   // A result is produced only when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> (!rsp_port.valid || rsp_port.ready))
      else $error("result produced while output register is blocked");

   // The table is never read and written in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(ram_req.rd_en && ram_req.wr_en))
      else $error("table read and write collide");

   // The clearing pass starts right after reset, with no transaction taken.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (!req_port.ready && ram_req.wr_en))
      else $error("clearing pass did not start after reset");

endmodule
